// ===== rtl/lru_pkg.sv =====
`default_nettype none

package lru_pkg;

	localparam int unsigned MAX_FRAMES_DEF = 16;
	localparam int unsigned PAGE_BITS_DEF  = 16;

	localparam int unsigned FIU_W       = 5;
	localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;

	localparam int unsigned FIELD_PAGE_W = 16;
	localparam int unsigned FRAME_IDX_W  = 4;
	localparam int unsigned FAULT_W      = 16;
	localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

	localparam int unsigned S_TDATA_W = 16;
	localparam int unsigned M_TDATA_W = 40;
	localparam int unsigned M_TUSER_W = 2;

	// first-match flags rippled from cell to cell
	typedef struct packed {
		logic hit_seen;
		logic empty_seen;
	} lru_chain_t;

	// broadcast to every cell
	typedef struct packed {
		logic upd;
		logic clear;
		logic hit;
		logic fill;
	} lru_ctrl_t;

	typedef struct packed {
		logic                    hit;
		logic [FRAME_IDX_W-1:0]  frame_index;
		logic                    evicted_valid;
		logic [FIELD_PAGE_W-1:0] evicted_page;
		logic [FAULT_W-1:0]      fault_count;
	} lru_result_t;

endpackage

`default_nettype wire

// ===== rtl/lru_cell.sv =====
`default_nettype none

module lru_cell import lru_pkg::*; #(
	parameter int unsigned IDX       = 0,
	parameter int unsigned PAGE_BITS = PAGE_BITS_DEF,
	parameter int unsigned RANK_W    = 4,
	parameter int unsigned CNT_W     = 5
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lru_ctrl_t            ctrl,
	input  wire logic [CNT_W-1:0]     count,
	input  wire logic [RANK_W-1:0]    oldest_rank,
	input  wire logic [RANK_W-1:0]    limit,
	input  wire logic [PAGE_BITS-1:0] page,
	input  wire lru_chain_t           chain_in,
	output lru_chain_t                chain_out,
	output logic                      sel,
	output logic [PAGE_BITS-1:0]      page_out,
	output logic [RANK_W-1:0]         rank_out
);

	logic                 valid_q;
	logic [RANK_W-1:0]    rank_q;
	logic [PAGE_BITS-1:0] page_q;
	logic                 active;
	logic                 match;
	logic                 empty;
	logic                 age;

	assign active = CNT_W'(IDX) < count;
	assign match  = active && valid_q && (page_q == page);
	assign empty  = active && !valid_q;

	assign chain_out.hit_seen   = chain_in.hit_seen || match;
	assign chain_out.empty_seen = chain_in.empty_seen || empty;

	always_comb begin
		if (ctrl.hit) begin
			sel = match && !chain_in.hit_seen;
		end else if (ctrl.fill) begin
			sel = empty && !chain_in.empty_seen;
		end else begin
			sel = active && (rank_q == oldest_rank);
		end
	end

	assign age = active && valid_q && !sel && (ctrl.fill || (rank_q < limit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (ctrl.upd && sel) begin
			valid_q <= 1'b1;
			rank_q  <= '0;
		end else if (ctrl.upd && age) begin
			rank_q <= rank_q + RANK_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.upd && sel && !ctrl.hit) begin
			page_q <= page;
		end
	end

	assign page_out = page_q;
	assign rank_out = rank_q;

endmodule

`default_nettype wire

// ===== rtl/lru_skid.sv =====
`default_nettype none

module lru_skid import lru_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire lru_result_t in_data,
	output logic             in_ready,
	output logic             out_valid,
	output lru_result_t      out_data,
	input  wire logic        out_ready
);

	logic        out_valid_q;
	logic        skid_valid_q;
	lru_result_t out_q;
	lru_result_t skid_q;
	logic        out_fire;

	assign out_fire = out_valid_q && out_ready;
	assign in_ready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_valid) begin
			if (out_valid_q && !out_fire) begin
				skid_valid_q <= 1'b1;
			end
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (in_valid) begin
			if (out_valid_q && !out_fire) begin
				skid_q <= in_data;
			end else begin
				out_q <= in_data;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== rtl/lru_page_replacement_core.sv =====
// LRU page replacement over a fully associative row of page frames. Each input transaction
// carries one page reference (tlast marks the last reference of a string, after which the
// frames and the fault count are cleared). One reference is accepted every clock cycle unless
// the output buffer is full, and its result is registered there; the rate is set by the
// combinational compare and recency update in the frame cells, where first-match flags ripple
// from cell to cell. A two-entry output buffer keeps the input ready while one result waits.
// Writing frames_in_use empties all frames and clears the fault count; 0 acts as one frame.
`default_nettype none

module lru_page_replacement_core import lru_pkg::*; #(
	parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF,
	parameter int unsigned PAGE_BITS  = PAGE_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,   // [15:0] page_number
	input  wire logic                 s_tlast,   // end_of_string
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// [3:0] frame_index, [19:4] evicted_page, [35:20] fault_count, [39:36] zero
	output logic [M_TDATA_W-1:0]      m_tdata,
	output logic [M_TUSER_W-1:0]      m_tuser,   // [0] hit, [1] evicted_valid
	input  wire logic                 cfg_we,
	input  wire logic [FIU_W-1:0]     cfg_wdata  // frames_in_use
);

	localparam int unsigned CNT_W  = $clog2(MAX_FRAMES + 1);
	localparam int unsigned RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

	logic [FIU_W-1:0]     fiu_q;
	logic [FAULT_W-1:0]   faults_q;
	logic [CNT_W-1:0]     count;
	logic [RANK_W-1:0]    oldest_rank;
	logic [RANK_W-1:0]    limit;
	logic [PAGE_BITS-1:0] page_in;
	logic                 in_fire;
	lru_ctrl_t            ctrl;
	lru_chain_t           chain [MAX_FRAMES+1];
	logic [MAX_FRAMES-1:0] sel_vec;
	logic [PAGE_BITS-1:0] page_arr [MAX_FRAMES];
	logic [RANK_W-1:0]    rank_arr [MAX_FRAMES];
	logic [FRAME_IDX_W-1:0] frame_idx;
	logic [PAGE_BITS-1:0] sel_page;
	logic [FAULT_W-1:0]   faults_next;
	lru_result_t          res;
	lru_result_t          out_res;

	always_comb begin
		if (fiu_q == '0) begin
			count = CNT_W'(1);
		end else if (32'(fiu_q) > MAX_FRAMES) begin
			count = CNT_W'(MAX_FRAMES);
		end else begin
			count = CNT_W'(fiu_q);
		end
	end

	assign oldest_rank = RANK_W'(count - CNT_W'(1));
	assign page_in     = PAGE_BITS'(s_tdata);
	assign in_fire     = s_tvalid && s_tready;

	assign chain[0] = '0;

	assign ctrl.upd   = in_fire;
	assign ctrl.clear = cfg_we || (in_fire && s_tlast);
	assign ctrl.hit   = chain[MAX_FRAMES].hit_seen;
	assign ctrl.fill  = !chain[MAX_FRAMES].hit_seen && chain[MAX_FRAMES].empty_seen;

	for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
		lru_cell #(
			.IDX       (i),
			.PAGE_BITS (PAGE_BITS),
			.RANK_W    (RANK_W),
			.CNT_W     (CNT_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.count       (count),
			.oldest_rank (oldest_rank),
			.limit       (limit),
			.page        (page_in),
			.chain_in    (chain[i]),
			.chain_out   (chain[i+1]),
			.sel         (sel_vec[i]),
			.page_out    (page_arr[i]),
			.rank_out    (rank_arr[i])
		);
	end

	always_comb begin
		limit     = '0;
		frame_idx = '0;
		sel_page  = '0;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			if (sel_vec[i]) begin
				limit     = limit | rank_arr[i];
				frame_idx = frame_idx | FRAME_IDX_W'(i);
				sel_page  = sel_page | page_arr[i];
			end
		end
	end

	always_comb begin
		if (ctrl.hit || (faults_q == FAULT_MAX)) begin
			faults_next = faults_q;
		end else begin
			faults_next = faults_q + FAULT_W'(1);
		end
	end

	always_comb begin
		res.hit           = ctrl.hit;
		res.frame_index   = frame_idx;
		res.evicted_valid = !ctrl.hit && !ctrl.fill;
		res.evicted_page  = res.evicted_valid ? FIELD_PAGE_W'(sel_page) : '0;
		res.fault_count   = faults_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q    <= FIU_RESET;
			faults_q <= '0;
		end else if (cfg_we) begin
			fiu_q    <= cfg_wdata;
			faults_q <= '0;
		end else if (in_fire) begin
			faults_q <= s_tlast ? '0 : faults_next;
		end
	end

	lru_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_fire),
		.in_data   (res),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_data  (out_res),
		.out_ready (m_tready)
	);

	assign m_tdata = {4'd0, out_res.fault_count, out_res.evicted_page, out_res.frame_index};
	assign m_tuser = {out_res.evicted_valid, out_res.hit};

endmodule

`default_nettype wire

// ===== rtl/lru_checker.sv =====
`default_nettype none

module lru_checker import lru_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic [M_TUSER_W-1:0] m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output transaction changed");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("hit reported together with an eviction");

	a_evict_page_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata[19:4] == '0)
		else $error("evicted page nonzero without eviction");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

endmodule

bind lru_page_replacement_core lru_checker u_lru_checker (.*);

`default_nettype wire
